@@ rtl/lmcf_pkg.sv @@
`default_nettype none
package lmcf_pkg;

	localparam int STORE_AW = 5;

	localparam logic [2:0] OP_DRAW    = 3'd0;
	localparam logic [2:0] OP_CLEAR   = 3'd1;
	localparam logic [2:0] OP_REFRESH = 3'd2;
	localparam logic [2:0] OP_INTENS  = 3'd3;
	localparam logic [2:0] OP_INIT    = 3'd4;

	localparam logic [7:0] REG_DECODE   = 8'h09;
	localparam logic [7:0] REG_TEST     = 8'h0F;
	localparam logic [7:0] REG_SCAN     = 8'h0B;
	localparam logic [7:0] REG_SHUTDOWN = 8'h0C;
	localparam logic [7:0] REG_INTENS   = 8'h0A;

	localparam logic [3:0] MAX_LEVEL = 4'd15;

	localparam logic [2:0] REFRESH_LAST_XFER = 3'd7;
	localparam logic [2:0] INIT_LAST_XFER    = 3'd4;

	localparam logic CFG_START_INTENSITY = 1'b0;
	localparam logic CFG_SCAN_LIMIT      = 1'b1;

	typedef enum logic [2:0] {
		K_DRAW,
		K_CLEAR,
		K_REFRESH,
		K_INTENS,
		K_INIT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [STORE_AW-1:0] idx;
		logic [2:0]          bitpos;
		logic                on;
		logic [3:0]          level;
	} cmd_t;

	function automatic logic [7:0] init_reg(input logic [2:0] step);
		logic [7:0] r;
		unique case (step)
			3'd0:    r = REG_DECODE;
			3'd1:    r = REG_TEST;
			3'd2:    r = REG_SCAN;
			3'd3:    r = REG_SHUTDOWN;
			default: r = REG_INTENS;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/led_matrix_chain_framebuffer.sv @@
// Framebuffer and command sequencer for a chain of up to four 8x8 LED matrix
// drivers. Commands enter on the s_ side (op in tuser) and land in a two-entry
// queue; draw and clear retire at dispatch in the back end, so pixel draws
// stream at one per cycle while the back end is not busy. Every other command
// sets the back end busy at dispatch, then refresh emits 8 transfers of
// 2*MODULES bytes, set intensity one transfer and init five transfers, one
// byte per cycle through the output register while m_tready holds; tlast
// closes each chain transfer (chip select release), tuser marks the final
// byte of a command. Draws outside the chain, row zero or above eight,
// intensity above 15 and unknown ops are dropped.
// Configuration: index 0 start_intensity (4 bits), index 1 scan_limit (3 bits).
`default_nettype none
module led_matrix_chain_framebuffer #(
	parameter int MODULES = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // pixel_x[4:0], pixel_y[8:5], pixel_on[9], level[17:10]
	input  wire logic [2:0]  s_tuser,  // op[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // spi_byte[7:0]
	output logic             m_tlast,  // transfer_end
	output logic             m_tuser,  // last
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [3:0]  cfg_data
);
	import lmcf_pkg::*;

	logic       q_full;
	logic       push;
	cmd_t       push_cmd;
	logic       q_valid;
	logic       pop;
	cmd_t       q_cmd;
	logic [3:0] start_intensity_q;
	logic [2:0] scan_limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_intensity_q <= 4'd2;
			scan_limit_q      <= 3'd7;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_START_INTENSITY: start_intensity_q <= cfg_data;
				CFG_SCAN_LIMIT:      scan_limit_q      <= cfg_data[2:0];
				default:             scan_limit_q      <= scan_limit_q;
			endcase
		end
	end

	lmcf_front #(.MODULES(MODULES)) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	lmcf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.q_valid  (q_valid),
		.pop      (pop),
		.q_cmd    (q_cmd)
	);

	lmcf_back #(.MODULES(MODULES)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_cmd           (q_cmd),
		.pop             (pop),
		.start_intensity (start_intensity_q),
		.scan_limit      (scan_limit_q),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tlast         (m_tlast),
		.m_tuser         (m_tuser)
	);

endmodule
`default_nettype wire

@@ rtl/lmcf_front.sv @@
`default_nettype none
module lmcf_front #(
	parameter int MODULES = 4
) (
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [23:0]       s_tdata,
	input  wire logic [2:0]        s_tuser,
	input  wire logic              q_full,
	output logic                   push,
	output lmcf_pkg::cmd_t         push_cmd
);
	import lmcf_pkg::*;

	logic [4:0] x;
	logic [3:0] y;
	logic       on;
	logic [7:0] level;
	logic [1:0] module_sel;
	logic [2:0] row;
	logic       keep;

	assign x          = s_tdata[4:0];
	assign y          = s_tdata[8:5];
	assign on         = s_tdata[9];
	assign level      = s_tdata[17:10];
	assign module_sel = x[4:3];
	assign row        = 3'(4'd8 - y);
	assign s_tready   = !q_full;

	always_comb begin
		keep            = 1'b0;
		push_cmd.kind   = K_CLEAR;
		push_cmd.idx    = STORE_AW'(int'(row) * MODULES + (MODULES - 1 - int'(module_sel)));
		push_cmd.bitpos = x[2:0];
		push_cmd.on     = on;
		push_cmd.level  = level[3:0];
		unique case (s_tuser)
			OP_DRAW: begin
				push_cmd.kind = K_DRAW;
				keep = (y != 4'd0) && (y <= 4'd8) && (int'(module_sel) < MODULES);
			end
			OP_CLEAR: begin
				push_cmd.kind = K_CLEAR;
				keep = 1'b1;
			end
			OP_REFRESH: begin
				push_cmd.kind = K_REFRESH;
				keep = 1'b1;
			end
			OP_INTENS: begin
				push_cmd.kind = K_INTENS;
				keep = (level <= {4'd0, MAX_LEVEL});
			end
			OP_INIT: begin
				push_cmd.kind = K_INIT;
				keep = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign push = s_tvalid && s_tready && keep;

endmodule
`default_nettype wire

@@ rtl/lmcf_queue.sv @@
`default_nettype none
module lmcf_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire lmcf_pkg::cmd_t  push_cmd,
	output logic                 full,
	output logic                 q_valid,
	input  wire logic            pop,
	output lmcf_pkg::cmd_t       q_cmd
);
	import lmcf_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign q_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

endmodule
`default_nettype wire

@@ rtl/lmcf_back.sv @@
`default_nettype none
module lmcf_back #(
	parameter int MODULES = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire lmcf_pkg::cmd_t  q_cmd,
	output logic                 pop,
	input  wire logic [3:0]      start_intensity,
	input  wire logic [2:0]      scan_limit,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [7:0]           m_tdata,
	output logic                 m_tlast,
	output logic                 m_tuser
);
	import lmcf_pkg::*;

	localparam int DEPTH = 8 * MODULES;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = (MODULES > 1) ? $clog2(MODULES) : 1;

	logic [7:0]    frame_q [DEPTH];
	cmd_t          cur_q;
	logic          busy_q;
	logic [2:0]    xfer_q;
	logic [PW-1:0] pair_q;
	logic          half_q;
	logic          valid_q;
	logic [7:0]    data_q;
	logic          tlast_q;
	logic          tuser_q;

	logic          slot_free;
	logic [AW-1:0] rd_addr;
	logic [7:0]    reg_byte;
	logic [7:0]    val_byte;
	logic [2:0]    last_xfer;
	logic          pair_end;
	logic          xfer_end;
	logic          cmd_end;

	assign slot_free = !valid_q || m_tready;
	assign pop       = !busy_q && q_valid;
	assign rd_addr   = AW'(int'(xfer_q) * MODULES + int'(pair_q));
	assign pair_end  = (pair_q == PW'(MODULES - 1));
	assign xfer_end  = half_q && pair_end;
	assign cmd_end   = xfer_end && (xfer_q == last_xfer);

	always_comb begin
		reg_byte  = REG_INTENS;
		val_byte  = {4'd0, cur_q.level};
		last_xfer = 3'd0;
		unique case (cur_q.kind)
			K_REFRESH: begin
				reg_byte  = {5'd0, xfer_q} + 8'd1;
				val_byte  = frame_q[rd_addr];
				last_xfer = REFRESH_LAST_XFER;
			end
			K_INIT: begin
				reg_byte  = init_reg(xfer_q);
				last_xfer = INIT_LAST_XFER;
				unique case (xfer_q)
					3'd2:    val_byte = {5'd0, scan_limit};
					3'd3:    val_byte = 8'd1;
					3'd4:    val_byte = {4'd0, start_intensity};
					default: val_byte = 8'd0;
				endcase
			end
			default: begin
				reg_byte  = REG_INTENS;
				val_byte  = {4'd0, cur_q.level};
				last_xfer = 3'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= q_cmd;
		if (busy_q && slot_free) begin
			data_q  <= half_q ? val_byte : reg_byte;
			tlast_q <= xfer_end;
			tuser_q <= cmd_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) frame_q[i] <= 8'd0;
			busy_q  <= 1'b0;
			xfer_q  <= 3'd0;
			pair_q  <= '0;
			half_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (busy_q && slot_free) valid_q <= 1'b1;
			else if (m_tready) valid_q <= 1'b0;
			if (busy_q) begin
				if (slot_free) begin
					half_q  <= !half_q;
					if (half_q) begin
						if (pair_end) begin
							pair_q <= '0;
							xfer_q <= xfer_q + 3'd1;
						end else begin
							pair_q <= pair_q + PW'(1);
						end
					end
					if (cmd_end) busy_q <= 1'b0;
				end
			end else if (q_valid) begin
				xfer_q <= 3'd0;
				pair_q <= '0;
				half_q <= 1'b0;
				unique case (q_cmd.kind)
					K_DRAW: frame_q[q_cmd.idx[AW-1:0]][q_cmd.bitpos] <= q_cmd.on;
					K_CLEAR: for (int i = 0; i < DEPTH; i++) frame_q[i] <= 8'd0;
					default: busy_q <= 1'b1;
				endcase
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = tlast_q;
	assign m_tuser  = tuser_q;

endmodule
`default_nettype wire
